// ----- hdl/one_wire_request_response_master_core_defines.svh -----
// Assertion macros for the single-wire request/response master.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ONE_WIRE_REQUEST_RESPONSE_MASTER_CORE_DEFINES_SVH
`define ONE_WIRE_REQUEST_RESPONSE_MASTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define OWRRM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent
`define OWRRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OWRRM_ASSERT_SAME(lbl, ante, cons, msg)
`define OWRRM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hdl/owrrm_pkg.sv -----
package owrrm_pkg;

    // Item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // CRC-8, MSB first
    localparam logic [7:0] CRC_INIT = 8'hAC;
    localparam logic [7:0] CRC_POLY = 8'h07;

    // Request codes used for reply classification
    localparam logic [7:0] REQ_TOUCH = 8'h40;
    localparam logic [7:0] REQ_IDENT = 8'h60;

    // Reply classes
    localparam logic [1:0] CLS_TOUCH = 2'd0;
    localparam logic [1:0] CLS_INFO  = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    // Timing of a session, in ticks
    localparam logic [5:0] START_TICKS = 6'd1;
    localparam logic [5:0] FRAME_BITS  = 6'd16;
    localparam logic [5:0] TURN_TICKS  = 6'd2;
    localparam logic [5:0] REPLY_BITS  = 6'd32;
    localparam logic [5:0] STOP_TICKS  = 6'd2;
    // Reply bits still to come once the CRC byte starts arriving
    localparam logic [5:0] CRC_TAIL    = 6'd8;

    localparam logic [31:0] ERR_AFTER    = 32'd100;
    localparam logic [1:0]  REJECT_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_REQUEST   = 3'd2,
        PH_WAITING   = 3'd3,
        PH_RESPONSE  = 3'd4,
        PH_STOPPING  = 3'd5
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] request_byte;
        logic       line_sample;
    } t_in_item;

    typedef struct packed {
        logic        line_level;
        logic        line_driven;
        logic        busy_res;
        logic        start_taken;
        logic        session_done;
        logic        crc_good;
        logic [23:0] reply_payload;
        logic [1:0]  reply_class;
        logic [31:0] sessions_received;
        logic [31:0] sessions_bad;
    } t_out_item;

    // One message bit into the CRC
    function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
        logic fb;
        fb = crc[7] ^ b;
        return {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    endfunction

    // One byte into the CRC, eight narrow steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] v);
        logic [7:0] c;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            c = crc8_bit(c, v[i]);
        end
        return c;
    endfunction

endpackage

// ----- hdl/one_wire_request_response_master_core.sv -----
// Single-wire request/response master, one result per item.
// Each item passes through the input register, then the result register.
// Throughput: one item per cycle unless stalled; one more item enters while a result waits.
// Reply CRC is accumulated bit by bit as the reply arrives, so no stage exceeds one byte step.
// Reset (synchronous, active low): idle, counters zero, wire driven high, both stages empty.
`include "one_wire_request_response_master_core_defines.svh"

module one_wire_request_response_master_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  owrrm_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output owrrm_pkg::t_out_item o_out_data
);

    logic                 r_in_vld;
    owrrm_pkg::t_in_item  r_in_data;
    logic                 r_out_vld;
    owrrm_pkg::t_out_item r_out_data;
    owrrm_pkg::t_out_item step_result;
    logic                 out_ready;
    logic                 advance;
    logic                 in_take;

    // Pipeline flow control
    assign out_ready  = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_ready;
    assign o_in_stall = r_in_vld && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    owrrm_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_data),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_ready) begin
            r_out_vld <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // Checks on result consistency
    `OWRRM_ASSERT_SAME(a_start_drives_low, r_out_vld && r_out_data.start_taken,
        r_out_data.busy_res && r_out_data.line_driven && !r_out_data.line_level,
        "start transfer must drive the wire low and be busy")
    `OWRRM_ASSERT_SAME(a_done_in_stop, r_out_vld && r_out_data.session_done,
        r_out_data.busy_res && r_out_data.line_driven && r_out_data.line_level,
        "session end must leave the wire driven high while stopping")
    `OWRRM_ASSERT_SAME(a_idle_fields_zero, r_out_vld && !r_out_data.session_done,
        !r_out_data.crc_good && r_out_data.reply_payload == 24'd0 &&
        r_out_data.reply_class == owrrm_pkg::CLS_TOUCH,
        "reply fields must be zero outside session end")
    `OWRRM_ASSERT_SAME(a_idle_drives, r_out_vld && !r_out_data.busy_res,
        r_out_data.line_driven,
        "idle master must drive the wire")
    `OWRRM_ASSERT_NEXT(a_advance_fills, advance, r_out_vld,
        "result register must hold a result after a step")

endmodule

// ----- hdl/owrrm_step.sv -----
module owrrm_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  owrrm_pkg::t_in_item  i_item,
    output owrrm_pkg::t_out_item o_result
);

    owrrm_pkg::t_phase r_phase, n_phase;
    logic [5:0]  r_ticks, n_ticks, ticks_dec;
    logic [31:0] r_shift, n_shift;
    logic [7:0]  r_pending, n_pending;
    logic [1:0]  r_rejects, n_rejects;
    logic [31:0] r_recv, n_recv;
    logic [31:0] r_err, n_err;
    logic        r_level, n_level;
    logic        r_enable, n_enable;
    // running CRC of the reply, updated bit by bit
    logic [7:0]  r_crc, n_crc;

    logic        go;
    logic        taken, done, good;
    logic [23:0] payload;
    logic [1:0]  cls;

    assign ticks_dec = r_ticks - 6'd1;

    // Next state for one item
    always_comb begin
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_shift   = r_shift;
        n_pending = r_pending;
        n_rejects = r_rejects;
        n_recv    = r_recv;
        n_err     = r_err;
        n_level   = r_level;
        n_enable  = r_enable;
        n_crc     = r_crc;
        go        = 1'b0;
        taken     = 1'b0;
        done      = 1'b0;
        good      = 1'b0;
        payload   = 24'd0;
        cls       = owrrm_pkg::CLS_TOUCH;

        if (i_item.kind == owrrm_pkg::KIND_START) begin
            // busy start: count rejects, restart once the limit is reached
            if (r_phase != owrrm_pkg::PH_IDLE && r_rejects != owrrm_pkg::REJECT_LIMIT) begin
                n_rejects = r_rejects + 2'd1;
            end
            go = (r_phase == owrrm_pkg::PH_IDLE) || (n_rejects == owrrm_pkg::REJECT_LIMIT);
            if (go) begin
                n_phase   = owrrm_pkg::PH_START;
                n_shift   = {i_item.request_byte,
                             owrrm_pkg::crc8_byte(owrrm_pkg::CRC_INIT, i_item.request_byte),
                             16'd0};
                n_pending = i_item.request_byte;
                n_ticks   = owrrm_pkg::START_TICKS;
                n_enable  = 1'b1;
                n_level   = 1'b0;
                taken     = 1'b1;
            end
        end else begin
            n_ticks = ticks_dec;
            case (r_phase)
                owrrm_pkg::PH_IDLE: begin
                end
                owrrm_pkg::PH_START: begin
                    if (ticks_dec == 6'd0) begin
                        n_ticks = owrrm_pkg::FRAME_BITS;
                        n_phase = owrrm_pkg::PH_REQUEST;
                    end
                end
                owrrm_pkg::PH_REQUEST: begin
                    n_level = r_shift[31];
                    n_shift = {r_shift[30:0], 1'b0};
                    if (ticks_dec == 6'd0) begin
                        n_ticks = owrrm_pkg::TURN_TICKS;
                        n_phase = owrrm_pkg::PH_WAITING;
                    end
                end
                owrrm_pkg::PH_WAITING: begin
                    if (ticks_dec == 6'd0) begin
                        n_ticks = owrrm_pkg::REPLY_BITS;
                        n_phase = owrrm_pkg::PH_RESPONSE;
                        n_crc   = owrrm_pkg::CRC_INIT;
                    end
                    // release the wire one tick before the reply
                    if (ticks_dec == 6'd1) begin
                        n_enable = 1'b0;
                        n_level  = 1'b1;
                    end
                end
                owrrm_pkg::PH_RESPONSE: begin
                    n_shift = {r_shift[30:0], i_item.line_sample};
                    if (ticks_dec >= owrrm_pkg::CRC_TAIL) begin
                        n_crc = owrrm_pkg::crc8_bit(r_crc, i_item.line_sample);
                    end
                    if (ticks_dec == 6'd0) begin
                        n_ticks  = owrrm_pkg::STOP_TICKS;
                        n_phase  = owrrm_pkg::PH_STOPPING;
                        n_level  = 1'b1;
                        n_enable = 1'b1;
                        n_recv   = r_recv + 32'd1;
                        done     = 1'b1;
                        payload  = n_shift[31:8];
                        good     = (r_crc == n_shift[7:0]);
                        if (!good && n_recv > owrrm_pkg::ERR_AFTER) begin
                            n_err = r_err + 32'd1;
                        end
                        if (r_pending == owrrm_pkg::REQ_TOUCH) begin
                            cls = owrrm_pkg::CLS_TOUCH;
                        end else if (r_pending == owrrm_pkg::REQ_IDENT) begin
                            cls = owrrm_pkg::CLS_INFO;
                        end else begin
                            cls = owrrm_pkg::CLS_OTHER;
                        end
                    end
                end
                owrrm_pkg::PH_STOPPING: begin
                    if (ticks_dec == 6'd0) begin
                        n_phase = owrrm_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = owrrm_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Result of this item, taken from the updated state
    always_comb begin
        o_result.line_level        = n_level;
        o_result.line_driven       = n_enable;
        o_result.busy_res          = (n_phase != owrrm_pkg::PH_IDLE);
        o_result.start_taken       = taken;
        o_result.session_done      = done;
        o_result.crc_good          = good;
        o_result.reply_payload     = payload;
        o_result.reply_class       = cls;
        o_result.sessions_received = n_recv;
        o_result.sessions_bad      = n_err;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= owrrm_pkg::PH_IDLE;
            r_ticks   <= 6'd0;
            r_shift   <= 32'd0;
            r_pending <= 8'd0;
            r_rejects <= 2'd0;
            r_recv    <= 32'd0;
            r_err     <= 32'd0;
            r_level   <= 1'b1;
            r_enable  <= 1'b1;
            r_crc     <= owrrm_pkg::CRC_INIT;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_shift   <= n_shift;
            r_pending <= n_pending;
            r_rejects <= n_rejects;
            r_recv    <= n_recv;
            r_err     <= n_err;
            r_level   <= n_level;
            r_enable  <= n_enable;
            r_crc     <= n_crc;
        end
    end

endmodule

// ----- tb/one_wire_request_response_master_core_tb.sv -----
`timescale 1ns / 1ps

module one_wire_request_response_master_core_tb;

    localparam int QUIET_LIMIT    = 2000;
    localparam int ITEM_TARGET    = 1850;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AFTER     = 400;
    localparam int SHOW_LIMIT     = 10;

    // Tracks the master's session state and holds the results each transfer should produce
    class wire_master_tracker;
        owrrm_pkg::t_phase    phase;
        logic [5:0]           ticks_left;
        logic [31:0]          shift_word;
        logic [7:0]           pending_req;
        logic [1:0]           rejects;
        logic [31:0]          rx_total;
        logic [31:0]          bad_total;
        logic                 drv_level;
        logic                 drv_en;
        owrrm_pkg::t_out_item due_outputs[$];
        int                   mismatches;
        int                   strays;

        function new();
            phase       = owrrm_pkg::PH_IDLE;
            ticks_left  = '0;
            shift_word  = '0;
            pending_req = '0;
            rejects     = '0;
            rx_total    = '0;
            bad_total   = '0;
            drv_level   = 1'b1;
            drv_en      = 1'b1;
            mismatches  = 0;
            strays      = 0;
        endfunction

        // CRC-8 over one byte, MSB first
        static function logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] v);
            logic [7:0] c;
            c = crc ^ v;
            for (int i = 0; i < 8; i++)
                c = c[7] ? ({c[6:0], 1'b0} ^ owrrm_pkg::CRC_POLY) : {c[6:0], 1'b0};
            return c;
        endfunction

        // Advance the state by one accepted input transfer and queue its result
        function void note_transfer(owrrm_pkg::t_in_item it);
            owrrm_pkg::t_out_item r;
            logic                 go;
            logic [7:0]           c;
            r = '0;
            if (it.kind == owrrm_pkg::KIND_START) begin
                go = 1'b1;
                // busy start: rejects saturate, restart once the limit is hit
                if (phase != owrrm_pkg::PH_IDLE) begin
                    if (rejects < owrrm_pkg::REJECT_LIMIT) rejects = rejects + 2'd1;
                    if (rejects < owrrm_pkg::REJECT_LIMIT) go = 1'b0;
                end
                if (go) begin
                    phase       = owrrm_pkg::PH_START;
                    shift_word  = {it.request_byte,
                                   crc8_next(owrrm_pkg::CRC_INIT, it.request_byte),
                                   16'h0000};
                    pending_req = it.request_byte;
                    ticks_left  = owrrm_pkg::START_TICKS;
                    drv_en      = 1'b1;
                    drv_level   = 1'b0;
                    r.start_taken = 1'b1;
                end
            end else begin
                // tick counter runs even when idle, wrapping at 64
                ticks_left = ticks_left - 6'd1;
                case (phase)
                    owrrm_pkg::PH_IDLE: ;
                    owrrm_pkg::PH_START: begin
                        if (ticks_left == '0) begin
                            ticks_left = owrrm_pkg::FRAME_BITS;
                            phase      = owrrm_pkg::PH_REQUEST;
                        end
                    end
                    owrrm_pkg::PH_REQUEST: begin
                        drv_level  = shift_word[31];
                        shift_word = shift_word << 1;
                        if (ticks_left == '0) begin
                            ticks_left = owrrm_pkg::TURN_TICKS;
                            phase      = owrrm_pkg::PH_WAITING;
                        end
                    end
                    owrrm_pkg::PH_WAITING: begin
                        if (ticks_left == '0) begin
                            ticks_left = owrrm_pkg::REPLY_BITS;
                            phase      = owrrm_pkg::PH_RESPONSE;
                        end
                        if (ticks_left == 6'd1) begin
                            drv_en    = 1'b0;
                            drv_level = 1'b1;
                        end
                    end
                    owrrm_pkg::PH_RESPONSE: begin
                        shift_word = {shift_word[30:0], it.line_sample};
                        if (ticks_left == '0) begin
                            ticks_left = owrrm_pkg::STOP_TICKS;
                            phase      = owrrm_pkg::PH_STOPPING;
                            drv_level  = 1'b1;
                            drv_en     = 1'b1;
                            rx_total   = rx_total + 32'd1;
                            c = crc8_next(crc8_next(crc8_next(owrrm_pkg::CRC_INIT,
                                                              shift_word[31:24]),
                                                    shift_word[23:16]), shift_word[15:8]);
                            r.session_done  = 1'b1;
                            r.reply_payload = shift_word[31:8];
                            r.crc_good      = (c == shift_word[7:0]);
                            // errors only count once past the warm-up sessions
                            if (!r.crc_good && rx_total > owrrm_pkg::ERR_AFTER)
                                bad_total = bad_total + 32'd1;
                            if (pending_req == owrrm_pkg::REQ_TOUCH)
                                r.reply_class = owrrm_pkg::CLS_TOUCH;
                            else if (pending_req == owrrm_pkg::REQ_IDENT)
                                r.reply_class = owrrm_pkg::CLS_INFO;
                            else
                                r.reply_class = owrrm_pkg::CLS_OTHER;
                        end
                    end
                    owrrm_pkg::PH_STOPPING: begin
                        if (ticks_left == '0) phase = owrrm_pkg::PH_IDLE;
                    end
                    default: phase = owrrm_pkg::PH_IDLE;
                endcase
            end
            r.line_level        = drv_level;
            r.line_driven       = drv_en;
            r.busy_res          = (phase != owrrm_pkg::PH_IDLE);
            r.sessions_received = rx_total;
            r.sessions_bad      = bad_total;
            due_outputs.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                             $time, field, want, got);
            end
        endfunction

        // Compare an accepted result transfer with the oldest queued one
        function void check_transfer(owrrm_pkg::t_out_item got);
            owrrm_pkg::t_out_item want;
            if (due_outputs.size() == 0) begin
                strays++;
                if (strays <= SHOW_LIMIT)
                    $display("%0t: result 0x%0h with none outstanding", $time, got);
                return;
            end
            want = due_outputs.pop_front();
            compare_field("line_level", want.line_level, got.line_level);
            compare_field("line_driven", want.line_driven, got.line_driven);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("start_taken", want.start_taken, got.start_taken);
            compare_field("session_done", want.session_done, got.session_done);
            compare_field("crc_good", want.crc_good, got.crc_good);
            compare_field("reply_payload", want.reply_payload, got.reply_payload);
            compare_field("reply_class", want.reply_class, got.reply_class);
            compare_field("sessions_received", want.sessions_received, got.sessions_received);
            compare_field("sessions_bad", want.sessions_bad, got.sessions_bad);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    owrrm_pkg::t_in_item  in_data;
    logic                 out_valid;
    logic                 out_stall;
    owrrm_pkg::t_out_item out_data;

    wire_master_tracker tracker;

    int tx_pct;
    int rx_pct;
    bit calm;
    int sent;
    int items_in;
    int quiet_cycles;

    one_wire_request_response_master_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, with an occasional idle burst first; returns once transferred
    task automatic send_item(owrrm_pkg::t_in_item it);
        if (!calm && $urandom_range(0, 99) < tx_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic send_start(logic [7:0] req);
        owrrm_pkg::t_in_item it;
        it.kind         = owrrm_pkg::KIND_START;
        it.request_byte = req;
        it.line_sample  = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_tick(logic level);
        owrrm_pkg::t_in_item it;
        it.kind         = owrrm_pkg::KIND_TICK;
        it.request_byte = 8'($urandom);
        it.line_sample  = level;
        send_item(it);
    endtask

    function automatic logic [7:0] pick_request();
        case ($urandom_range(0, 9))
            0, 1, 2: return owrrm_pkg::REQ_TOUCH;
            3, 4, 5: return owrrm_pkg::REQ_IDENT;
            6:       return 8'h00;
            7:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 10;
            default: return 30;
        endcase
    endfunction

    // Full well-formed session; the reply carries a good CRC most of the time
    task automatic run_session(logic [7:0] req);
        logic [23:0] body;
        logic [7:0]  sum8;
        logic [31:0] reply;
        case ($urandom_range(0, 9))
            0:       body = '0;
            1:       body = '1;
            default: body = 24'($urandom);
        endcase
        sum8 = wire_master_tracker::crc8_next(
                   wire_master_tracker::crc8_next(
                       wire_master_tracker::crc8_next(owrrm_pkg::CRC_INIT, body[23:16]),
                       body[15:8]),
                   body[7:0]);
        if ($urandom_range(0, 9) < 4) sum8 = sum8 ^ 8'($urandom_range(1, 255));
        reply = {body, sum8};
        send_start(req);
        repeat (owrrm_pkg::START_TICKS + owrrm_pkg::FRAME_BITS + owrrm_pkg::TURN_TICKS)
            send_tick(1'($urandom));
        for (int i = 31; i >= 0; i--) send_tick(reply[i]);
        repeat (owrrm_pkg::STOP_TICKS) send_tick(1'($urandom));
    endtask

    // Monitor both channels on the clock edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                tracker.note_transfer(in_data);
                items_in++;
            end
            if (out_valid && !out_stall) tracker.check_transfer(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog on cycles without any transfer
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Result side: random stall bursts and one long hold-off
    initial begin : out_side
        bit held;
        held = 1'b0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (calm) begin
                out_stall <= 1'b0;
            end else if (!held && items_in > HOLD_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < rx_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus
    initial begin
        int pick;
        tracker      = new();
        calm         = 1'b0;
        tx_pct       = 0;
        rx_pct       = 0;
        sent         = 0;
        items_in     = 0;
        quiet_cycles = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle ticks wrap the counter, then busy starts up to the forced restart
        send_tick(1'b0);
        send_tick(1'b1);
        send_start(8'h00);
        send_start(8'hFF);
        send_start(owrrm_pkg::REQ_TOUCH);
        send_start(owrrm_pkg::REQ_IDENT);
        send_tick(1'b1);
        send_start(owrrm_pkg::REQ_TOUCH);

        // random: mostly whole sessions, plus cut-short sessions, stray ticks and starts
        while (sent < ITEM_TARGET) begin
            tx_pct = pick_rate();
            rx_pct = pick_rate();
            pick   = $urandom_range(0, 99);
            if (pick < 70) begin
                run_session(pick_request());
            end else if (pick < 82) begin
                send_start(pick_request());
                repeat ($urandom_range(0, 52)) send_tick(1'($urandom));
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom));
            end else begin
                send_start(pick_request());
                send_start(pick_request());
            end
        end

        // closing stretch at full rate on both sides
        calm = 1'b1;
        repeat (3) run_session(pick_request());
        in_valid <= 1'b0;

        while (tracker.due_outputs.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.strays == 0 && tracker.due_outputs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
